/* rtl/clfp_pkg.sv */
// ----------------------------------------------------------------------------
// clfp_pkg
// Shared types and constants for the cursor list with free pool: pool size,
// link widths, request and status codes, sequencer states and the write
// request that the sequencer sends to the node store.
// ----------------------------------------------------------------------------
`default_nettype none

package clfp_pkg;

    localparam int NODES = 16;
    localparam int IDX_W = $clog2(NODES);
    localparam int PTR_W = $clog2(NODES + 1);
    localparam int VAL_W = 8;

    localparam logic [PTR_W-1:0] NIL = PTR_W'(NODES);

    typedef enum logic [1:0] {
        FN_FIRST  = 2'd0,
        FN_REAR   = 2'd1,
        FN_SORTED = 2'd2,
        FN_REMOVE = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_MISSING = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_WALK,
        S_LINK,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic             next_en;
        logic [IDX_W-1:0] next_addr;
        logic [PTR_W-1:0] next_data;
        logic             val_en;
        logic [IDX_W-1:0] val_addr;
        logic [VAL_W-1:0] val_data;
    } store_wr_t;

endpackage

`default_nettype wire

/* rtl/clfp_store.sv */
// ----------------------------------------------------------------------------
// clfp_store
// Node store: one byte and one link per slot, one read address per cycle,
// one link write and one value write per cycle. Links reset to the initial
// free chain, each slot pointing at the slot below.
// ----------------------------------------------------------------------------
`default_nettype none

module clfp_store (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire  [clfp_pkg::IDX_W-1:0]      rd_addr,
    output logic [clfp_pkg::VAL_W-1:0]      rd_value,
    output logic [clfp_pkg::PTR_W-1:0]      rd_next,
    input  clfp_pkg::store_wr_t             wr
);

    logic [clfp_pkg::VAL_W-1:0] value_reg [clfp_pkg::NODES];
    logic [clfp_pkg::PTR_W-1:0] next_reg  [clfp_pkg::NODES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int x = 0; x < clfp_pkg::NODES; x++) begin
                next_reg[x] <= (x == 0) ? clfp_pkg::NIL : clfp_pkg::PTR_W'(x - 1);
            end
        end else if (wr.next_en) begin
            next_reg[wr.next_addr] <= wr.next_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.val_en) begin
            value_reg[wr.val_addr] <= wr.val_data;
        end
    end

    assign rd_value = value_reg[rd_addr];
    assign rd_next  = next_reg[rd_addr];

endmodule

`default_nettype wire

/* rtl/cursor_list_free_pool.sv */
// sequence: front insert, rear insert into an empty list and any insert into a
//   full pool go straight from start to finish; the rest walk the list first
// throughput: one request at a time, not ready from acceptance until the result is registered
// reset: synchronous active-low aresetn; empty list, all slots on the free
//   chain from the highest slot down, no result pending
// ----------------------------------------------------------------------------
// cursor_list_free_pool
// Linked list of bytes over a slot pool with a free chain. A small sequencer
// walks the list through the node store one link per cycle to insert at the
// rear or in ascending order, or to unlink a slot back to the free chain.
// ----------------------------------------------------------------------------
`default_nettype none

module cursor_list_free_pool (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [15:0] s_tdata,   // func[1:0], elem[9:2], node_index[13:10], zero pad
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [15:0] m_tdata    // status[1:0], slot[6:2], head[11:7], zero pad
);

    localparam int PW = clfp_pkg::PTR_W;
    localparam int IW = clfp_pkg::IDX_W;
    localparam int VW = clfp_pkg::VAL_W;

    clfp_pkg::state_t  state_reg, state_next;
    clfp_pkg::func_t   func_reg, func_next;
    logic [VW-1:0]     elem_reg, elem_next;
    logic [IW-1:0]     idx_reg, idx_next;
    logic [PW-1:0]     slot_reg, slot_next;
    logic [PW-1:0]     cur_reg, cur_next;
    logic [PW-1:0]     prev_reg, prev_next;
    logic [PW-1:0]     cnt_reg, cnt_next;
    logic [PW-1:0]     free_head_reg, free_head_next;
    logic [PW-1:0]     list_head_reg, list_head_next;
    clfp_pkg::status_t status_reg, status_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [15:0]       m_tdata_reg, m_tdata_next;

    logic [IW-1:0]       rd_addr;
    logic [VW-1:0]       rd_value;
    logic [PW-1:0]       rd_next;
    clfp_pkg::store_wr_t wr;
    logic                walk_on;

    clfp_store u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_addr  (rd_addr),
        .rd_value (rd_value),
        .rd_next  (rd_next),
        .wr       (wr)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= clfp_pkg::S_IDLE;
            free_head_reg <= clfp_pkg::NIL - PW'(1);
            list_head_reg <= clfp_pkg::NIL;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            free_head_reg <= free_head_next;
            list_head_reg <= list_head_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg    <= func_next;
        elem_reg    <= elem_next;
        idx_reg     <= idx_next;
        slot_reg    <= slot_next;
        cur_reg     <= cur_next;
        prev_reg    <= prev_next;
        cnt_reg     <= cnt_next;
        status_reg  <= status_next;
        m_tdata_reg <= m_tdata_next;
    end

    always_comb begin
        state_next     = state_reg;
        func_next      = func_reg;
        elem_next      = elem_reg;
        idx_next       = idx_reg;
        slot_next      = slot_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        cnt_next       = cnt_reg;
        free_head_next = free_head_reg;
        list_head_next = list_head_reg;
        status_next    = status_reg;
        m_tvalid_next  = m_tvalid_reg;
        m_tdata_next   = m_tdata_reg;
        wr             = '0;
        rd_addr        = cur_reg[IW-1:0];
        walk_on        = 1'b0;
        s_tready       = 1'b0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            clfp_pkg::S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    func_next  = clfp_pkg::func_t'(s_tdata[1:0]);
                    elem_next  = s_tdata[9:2];
                    idx_next   = s_tdata[13:10];
                    state_next = clfp_pkg::S_START;
                end
            end

            clfp_pkg::S_START: begin
                rd_addr   = free_head_reg[IW-1:0];
                status_next = clfp_pkg::ST_OK;
                prev_next = clfp_pkg::NIL;
                cur_next  = list_head_reg;
                cnt_next  = '0;
                if (func_reg == clfp_pkg::FN_REMOVE) begin
                    state_next = clfp_pkg::S_WALK;
                end else if (free_head_reg == clfp_pkg::NIL) begin
                    status_next = clfp_pkg::ST_FULL;
                    slot_next   = clfp_pkg::NIL;
                    state_next  = clfp_pkg::S_FINISH;
                end else begin
                    slot_next      = free_head_reg;
                    free_head_next = rd_next;
                    wr.val_en      = 1'b1;
                    wr.val_addr    = free_head_reg[IW-1:0];
                    wr.val_data    = elem_reg;
                    wr.next_addr   = free_head_reg[IW-1:0];
                    case (func_reg)
                        clfp_pkg::FN_FIRST: begin
                            wr.next_en     = 1'b1;
                            wr.next_data   = list_head_reg;
                            list_head_next = free_head_reg;
                            state_next     = clfp_pkg::S_FINISH;
                        end
                        clfp_pkg::FN_REAR: begin
                            wr.next_en   = 1'b1;
                            wr.next_data = clfp_pkg::NIL;
                            if (list_head_reg == clfp_pkg::NIL) begin
                                list_head_next = free_head_reg;
                                state_next     = clfp_pkg::S_FINISH;
                            end else begin
                                state_next = clfp_pkg::S_WALK;
                            end
                        end
                        default: begin
                            state_next = clfp_pkg::S_WALK;
                        end
                    endcase
                end
            end

            clfp_pkg::S_WALK: begin
                case (func_reg)
                    clfp_pkg::FN_REAR: begin
                        walk_on = (cnt_reg < clfp_pkg::NIL) && (rd_next < clfp_pkg::NIL);
                        if (walk_on) begin
                            cur_next = rd_next;
                            cnt_next = cnt_reg + PW'(1);
                        end else begin
                            wr.next_en   = 1'b1;
                            wr.next_addr = cur_reg[IW-1:0];
                            wr.next_data = slot_reg;
                            state_next   = clfp_pkg::S_FINISH;
                        end
                    end
                    clfp_pkg::FN_SORTED: begin
                        walk_on = (cnt_reg < clfp_pkg::NIL) && (cur_reg < clfp_pkg::NIL)
                                  && (elem_reg > rd_value);
                        wr.next_addr = slot_reg[IW-1:0];
                        if (walk_on) begin
                            prev_next = cur_reg;
                            cur_next  = rd_next;
                            cnt_next  = cnt_reg + PW'(1);
                        end else if (prev_reg == clfp_pkg::NIL) begin
                            wr.next_en     = 1'b1;
                            wr.next_data   = list_head_reg;
                            list_head_next = slot_reg;
                            state_next     = clfp_pkg::S_FINISH;
                        end else begin
                            wr.next_en   = 1'b1;
                            wr.next_data = cur_reg;
                            state_next   = clfp_pkg::S_LINK;
                        end
                    end
                    default: begin
                        walk_on = (cnt_reg < clfp_pkg::NIL) && (cur_reg < clfp_pkg::NIL)
                                  && (cur_reg != {1'b0, idx_reg});
                        if (walk_on) begin
                            prev_next = cur_reg;
                            cur_next  = rd_next;
                            cnt_next  = cnt_reg + PW'(1);
                        end else if (cur_reg != {1'b0, idx_reg}) begin
                            status_next = clfp_pkg::ST_MISSING;
                            slot_next   = clfp_pkg::NIL;
                            state_next  = clfp_pkg::S_FINISH;
                        end else begin
                            slot_next = {1'b0, idx_reg};
                            if (prev_reg == clfp_pkg::NIL) begin
                                list_head_next = rd_next;
                            end else begin
                                wr.next_en   = 1'b1;
                                wr.next_addr = prev_reg[IW-1:0];
                                wr.next_data = rd_next;
                            end
                            state_next = clfp_pkg::S_LINK;
                        end
                    end
                endcase
            end

            clfp_pkg::S_LINK: begin
                wr.next_en = 1'b1;
                if (func_reg == clfp_pkg::FN_REMOVE) begin
                    wr.next_addr   = idx_reg;
                    wr.next_data   = free_head_reg;
                    free_head_next = {1'b0, idx_reg};
                end else begin
                    wr.next_addr = prev_reg[IW-1:0];
                    wr.next_data = slot_reg;
                end
                state_next = clfp_pkg::S_FINISH;
            end

            clfp_pkg::S_FINISH: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {4'b0, list_head_reg, slot_reg, status_reg};
                    state_next    = clfp_pkg::S_IDLE;
                end
            end

            default: begin
                state_next = clfp_pkg::S_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire
